FILE: sv/gdc_pkg.sv
// shared types, constants and helpers of the gamepad deadzone conditioner
package gdc_pkg;

    localparam int AXIS_W     = 16;
    localparam int TRIG_W     = 8;
    localparam int BTN_W      = 16;
    localparam int OUT_W      = 16;
    localparam int FLAG_W     = 8;
    localparam int DZ_W       = 15;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int MAG_W  = AXIS_W + 1;
    localparam int AX2_W  = 2 * MAG_W - 3;
    localparam int DZ2_W  = 2 * DZ_W;
    localparam int SQ_W   = 32;
    localparam int FRAC_W = 8;
    localparam int D_W    = DZ_W + FRAC_W;
    localparam int NX_W   = 2 * MAG_W;

    localparam int ROOT_W         = 24;
    localparam int SQRT_REM_W     = ROOT_W + 3;
    localparam int SQRT_STEPS     = 24;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

    localparam int DIV_NUM_W     = 48;
    localparam int DIV_DEN_W     = 32;
    localparam int DIV_Q_W       = 17;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = (DIV_Q_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

    // stage positions along the pipeline
    localparam int P_ABS      = 0;
    localparam int P_SUM      = 1;
    localparam int P_SQRT     = 2;
    localparam int P_DIFF     = P_SQRT + SQRT_STAGES;
    localparam int P_SQR      = P_DIFF + 1;
    localparam int P_NDIV     = P_SQR + 1;
    localparam int P_SCALE    = P_NDIV + DIV_STAGES;
    localparam int P_VDIV     = P_SCALE + 1;
    localparam int P_OUT      = P_VDIV + DIV_STAGES;
    localparam int NUM_STAGES = P_OUT + 1;
    localparam int P_TDIV     = 1;

    localparam logic [OUT_W-1:0]  Q15_ONE   = 16'h8000;
    localparam logic [DZ_W-1:0]   MAX_MAG   = 15'h7fff;
    localparam logic [TRIG_W-1:0] TRIG_FULL = 8'hff;

    localparam logic [DZ_W-1:0]  LEFT_DZ_RST  = 15'd7849;
    localparam logic [DZ_W-1:0]  RIGHT_DZ_RST = 15'd8689;
    localparam logic [THR_W-1:0] THR_RST      = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_DZ  = 2'd0,
        REG_RIGHT_DZ = 2'd1,
        REG_TRIG_THR = 2'd2
    } cfg_reg_t;

    function automatic logic [OUT_W-1:0] sat_q15(input logic [DIV_Q_W-1:0] q);
        sat_q15 = (q > DIV_Q_W'(Q15_ONE)) ? Q15_ONE : q[OUT_W-1:0];
    endfunction

endpackage

FILE: sv/gdc_if.sv
// sample and result channel interfaces
interface gdc_in_if import gdc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] left_stick_x;
    logic signed [AXIS_W-1:0] left_stick_y;
    logic signed [AXIS_W-1:0] right_stick_x;
    logic signed [AXIS_W-1:0] right_stick_y;
    logic [TRIG_W-1:0]        left_trigger_raw;
    logic [TRIG_W-1:0]        right_trigger_raw;
    logic [BTN_W-1:0]         button_word;

    modport source (
        output valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
               left_trigger_raw, right_trigger_raw, button_word,
        input  ready
    );
    modport sink (
        input  valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
               left_trigger_raw, right_trigger_raw, button_word,
        output ready
    );
endinterface

interface gdc_out_if import gdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  left_x_positive;
    logic [OUT_W-1:0]  left_x_negative;
    logic [OUT_W-1:0]  left_y_positive;
    logic [OUT_W-1:0]  left_y_negative;
    logic [OUT_W-1:0]  right_x_positive;
    logic [OUT_W-1:0]  right_x_negative;
    logic [OUT_W-1:0]  right_y_positive;
    logic [OUT_W-1:0]  right_y_negative;
    logic [OUT_W-1:0]  trigger_positive;
    logic [OUT_W-1:0]  trigger_negative;
    logic [FLAG_W-1:0] button_flags;

    modport source (
        output valid, left_x_positive, left_x_negative, left_y_positive, left_y_negative,
               right_x_positive, right_x_negative, right_y_positive, right_y_negative,
               trigger_positive, trigger_negative, button_flags,
        input  ready
    );
    modport sink (
        input  valid, left_x_positive, left_x_negative, left_y_positive, left_y_negative,
               right_x_positive, right_x_negative, right_y_positive, right_y_negative,
               trigger_positive, trigger_negative, button_flags,
        output ready
    );
endinterface

FILE: sv/gdc_pipe_ctrl.sv
// stage valid bits and per-stage load enables with bubble collapsing
module gdc_pipe_ctrl import gdc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic [NUM_STAGES-1:0] en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en        = rdy;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

FILE: sv/gdc_sqrt.sv
// pipelined digit-by-digit square root of a radicand shifted up by 16 bits
module gdc_sqrt import gdc_pkg::*; (
    input  logic                   clk,
    input  logic [SQRT_STAGES-1:0] en,
    input  logic [SQ_W-1:0]        radicand,
    output logic [ROOT_W-1:0]      root
);

    typedef struct packed {
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
        logic [SQ_W-1:0]       rest;
    } sq_st_t;

    sq_st_t st_reg  [SQRT_STAGES];
    sq_st_t st_next [SQRT_STAGES];
    sq_st_t st_in   [SQRT_STAGES];

    always_comb
    begin
        sq_st_t                cur;
        logic [SQRT_REM_W-1:0] rem_w;
        logic [SQRT_REM_W-1:0] trial;
        st_in[0] = '{rem: '0, root: '0, rest: radicand};
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            st_in[s] = st_reg[s-1];
        end
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            cur = st_in[s];
            for (int k = 0; k < SQRT_PER_STAGE; k++)
            begin
                if (s * SQRT_PER_STAGE + k < SQRT_STEPS)
                begin
                    rem_w    = {cur.rem[SQRT_REM_W-3:0], cur.rest[SQ_W-1 -: 2]};
                    cur.rest = cur.rest << 2;
                    trial    = SQRT_REM_W'({cur.root, 2'b01});
                    if (rem_w >= trial)
                    begin
                        cur.rem  = rem_w - trial;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.rem  = rem_w;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            st_next[s] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (en[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign root = st_reg[SQRT_STAGES-1].root;

endmodule

FILE: sv/gdc_div.sv
// pipelined restoring divider with a short quotient
module gdc_div import gdc_pkg::*; (
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [DIV_NUM_W-1:0]  num,
    input  logic [DIV_DEN_W-1:0]  den,
    output logic [DIV_Q_W-1:0]    quo
);

    typedef struct packed {
        logic [DIV_DEN_W:0]   rem;
        logic [DIV_Q_W-1:0]   low;
        logic [DIV_Q_W-1:0]   q;
        logic [DIV_DEN_W-1:0] den;
    } div_st_t;

    div_st_t st_reg  [DIV_STAGES];
    div_st_t st_next [DIV_STAGES];
    div_st_t st_in   [DIV_STAGES];

    always_comb
    begin
        div_st_t cur;
        st_in[0].rem = (DIV_DEN_W+1)'(num[DIV_NUM_W-1:DIV_Q_W]);
        st_in[0].low = num[DIV_Q_W-1:0];
        st_in[0].q   = '0;
        st_in[0].den = den;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            st_in[s] = st_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            cur = st_in[s];
            for (int k = 0; k < DIV_PER_STAGE; k++)
            begin
                if (s * DIV_PER_STAGE + k < DIV_Q_W)
                begin
                    cur.rem = {cur.rem[DIV_DEN_W-1:0], cur.low[DIV_Q_W-1]};
                    cur.low = cur.low << 1;
                    if (cur.rem >= {1'b0, cur.den})
                    begin
                        cur.rem = cur.rem - {1'b0, cur.den};
                        cur.q   = {cur.q[DIV_Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        cur.q = {cur.q[DIV_Q_W-2:0], 1'b0};
                    end
                end
            end
            st_next[s] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign quo = st_reg[DIV_STAGES-1].q;

endmodule

FILE: sv/gdc_stick.sv
// one thumbstick lane: magnitude, radial deadzone, squared response, direction split
module gdc_stick import gdc_pkg::*; (
    input  logic                     clk,
    input  logic [NUM_STAGES-1:0]    en,
    input  logic [DZ_W-1:0]          deadzone,
    input  logic signed [AXIS_W-1:0] axis_x,
    input  logic signed [AXIS_W-1:0] axis_y,
    output logic [OUT_W-1:0]         x_positive,
    output logic [OUT_W-1:0]         x_negative,
    output logic [OUT_W-1:0]         y_positive,
    output logic [OUT_W-1:0]         y_negative
);

    typedef struct packed {
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic              xpos;
        logic              xneg;
        logic              ypos;
        logic              yneg;
        logic              zero;
        logic [ROOT_W-1:0] root;
    } stk_side_t;

    localparam logic [ROOT_W-1:0] RC_MAX = ROOT_W'({MAX_MAG, {FRAC_W{1'b0}}});

    stk_side_t side_reg  [P_OUT];
    stk_side_t side_next [P_OUT];

    logic signed [MAG_W-1:0] x_ext;
    logic signed [MAG_W-1:0] y_ext;
    logic [MAG_W-1:0]        abs_x;
    logic [MAG_W-1:0]        abs_y;
    logic [2*MAG_W-1:0]      ax2_full;
    logic [2*MAG_W-1:0]      ay2_full;
    logic [AX2_W-1:0]        ax2_reg;
    logic [AX2_W-1:0]        ay2_reg;
    logic [DZ2_W-1:0]        dz2_reg;
    logic [SQ_W-1:0]         sum_s;
    logic                    in_zone;
    logic [SQ_W-1:0]         s_reg;
    logic [ROOT_W-1:0]       root;
    logic [ROOT_W-1:0]       rc;
    logic [ROOT_W-1:0]       dz_q8;
    logic [ROOT_W-1:0]       d_full;
    logic                    too_close;
    logic [D_W-1:0]          d_reg;
    logic [2*D_W-1:0]        dd_full;
    logic [2*D_W-1:0]        dd_reg;
    logic [DZ_W-1:0]         span;
    logic [2*DZ_W-1:0]       span_sq;
    logic [DIV_DEN_W-1:0]    den2_reg;
    logic [DIV_Q_W-1:0]      n_q;
    logic [NX_W-1:0]         nx_full;
    logic [NX_W-1:0]         ny_full;
    logic [NX_W-1:0]         nx_reg;
    logic [NX_W-1:0]         ny_reg;
    logic [DIV_Q_W-1:0]      qx;
    logic [DIV_Q_W-1:0]      qy;
    logic [OUT_W-1:0]        vx;
    logic [OUT_W-1:0]        vy;
    stk_side_t               fin;
    logic [OUT_W-1:0]        x_positive_reg;
    logic [OUT_W-1:0]        x_negative_reg;
    logic [OUT_W-1:0]        y_positive_reg;
    logic [OUT_W-1:0]        y_negative_reg;

    assign x_ext    = MAG_W'(axis_x);
    assign y_ext    = MAG_W'(axis_y);
    assign abs_x    = x_ext[MAG_W-1] ? $unsigned(-x_ext) : $unsigned(x_ext);
    assign abs_y    = y_ext[MAG_W-1] ? $unsigned(-y_ext) : $unsigned(y_ext);
    assign ax2_full = abs_x * abs_x;
    assign ay2_full = abs_y * abs_y;

    assign sum_s   = SQ_W'(ax2_reg) + SQ_W'(ay2_reg);
    assign in_zone = sum_s <= SQ_W'(dz2_reg);

    assign rc        = (root > RC_MAX) ? RC_MAX : root;
    assign dz_q8     = ROOT_W'({deadzone, {FRAC_W{1'b0}}});
    assign too_close = rc <= dz_q8;
    assign d_full    = rc - dz_q8;

    assign dd_full = d_reg * d_reg;
    assign span    = MAX_MAG - deadzone;
    assign span_sq = span * span;

    assign nx_full = side_reg[P_SCALE-1].ax * n_q;
    assign ny_full = side_reg[P_SCALE-1].ay * n_q;

    always_comb
    begin
        side_next[P_ABS].ax   = abs_x;
        side_next[P_ABS].ay   = abs_y;
        side_next[P_ABS].xpos = !axis_x[AXIS_W-1] && (axis_x != '0);
        side_next[P_ABS].xneg = axis_x[AXIS_W-1];
        side_next[P_ABS].ypos = !axis_y[AXIS_W-1] && (axis_y != '0);
        side_next[P_ABS].yneg = axis_y[AXIS_W-1];
        side_next[P_ABS].zero = 1'b0;
        side_next[P_ABS].root = '0;
        for (int i = 1; i < P_OUT; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[P_SUM].zero  = side_reg[P_SUM-1].zero | in_zone;
        side_next[P_DIFF].zero = side_reg[P_DIFF-1].zero | too_close;
        side_next[P_DIFF].root = root;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < P_OUT; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_next[i];
            end
        end
        if (en[P_ABS])
        begin
            ax2_reg <= ax2_full[AX2_W-1:0];
            ay2_reg <= ay2_full[AX2_W-1:0];
            dz2_reg <= deadzone * deadzone;
        end
        if (en[P_SUM])
        begin
            s_reg <= sum_s;
        end
        if (en[P_DIFF])
        begin
            d_reg <= d_full[D_W-1:0];
        end
        if (en[P_SQR])
        begin
            dd_reg   <= dd_full;
            den2_reg <= DIV_DEN_W'({span_sq, 1'b0});
        end
        if (en[P_SCALE])
        begin
            nx_reg <= nx_full;
            ny_reg <= ny_full;
        end
        if (en[P_OUT])
        begin
            x_positive_reg <= (fin.xpos && !fin.zero) ? vx : '0;
            x_negative_reg <= (fin.xneg && !fin.zero) ? vx : '0;
            y_positive_reg <= (fin.ypos && !fin.zero) ? vy : '0;
            y_negative_reg <= (fin.yneg && !fin.zero) ? vy : '0;
        end
    end

    gdc_sqrt u_sqrt (
        .clk      (clk),
        .en       (en[P_SQRT +: SQRT_STAGES]),
        .radicand (s_reg),
        .root     (root)
    );

    // squared normalized magnitude, Q.15
    gdc_div u_ndiv (
        .clk (clk),
        .en  (en[P_NDIV +: DIV_STAGES]),
        .num (DIV_NUM_W'(dd_reg)),
        .den (den2_reg),
        .quo (n_q)
    );

    gdc_div u_xdiv (
        .clk (clk),
        .en  (en[P_VDIV +: DIV_STAGES]),
        .num (DIV_NUM_W'({nx_reg, {FRAC_W{1'b0}}})),
        .den (DIV_DEN_W'(side_reg[P_SCALE].root)),
        .quo (qx)
    );

    gdc_div u_ydiv (
        .clk (clk),
        .en  (en[P_VDIV +: DIV_STAGES]),
        .num (DIV_NUM_W'({ny_reg, {FRAC_W{1'b0}}})),
        .den (DIV_DEN_W'(side_reg[P_SCALE].root)),
        .quo (qy)
    );

    assign fin = side_reg[P_OUT-1];
    assign vx  = sat_q15(qx);
    assign vy  = sat_q15(qy);

    assign x_positive = x_positive_reg;
    assign x_negative = x_negative_reg;
    assign y_positive = y_positive_reg;
    assign y_negative = y_negative_reg;

endmodule

FILE: sv/gdc_trig.sv
// trigger difference lane: deadband, scaling to Q1.15, sign split
module gdc_trig import gdc_pkg::*; (
    input  logic                  clk,
    input  logic [NUM_STAGES-1:0] en,
    input  logic [THR_W-1:0]      threshold,
    input  logic [TRIG_W-1:0]     left_raw,
    input  logic [TRIG_W-1:0]     right_raw,
    output logic [OUT_W-1:0]      positive,
    output logic [OUT_W-1:0]      negative
);

    localparam int TD_W = TRIG_W + 2;

    typedef struct packed {
        logic               pos;
        logic               neg;
        logic [DIV_Q_W-1:0] q;
    } trig_line_t;

    trig_line_t line_reg  [P_OUT];
    trig_line_t line_next [P_OUT];

    logic [THR_W-2:0]        half;
    logic signed [TD_W-1:0]  delta;
    logic signed [TD_W-1:0]  hs;
    logic signed [TD_W-1:0]  adj;
    logic signed [TD_W-1:0]  mag_abs;
    logic [TRIG_W-1:0]       mag_reg;
    logic [TRIG_W-1:0]       tden;
    logic [DIV_Q_W-1:0]      quo;
    logic [OUT_W-1:0]        mag_sat;
    logic [OUT_W-1:0]        positive_reg;
    logic [OUT_W-1:0]        negative_reg;

    assign half  = threshold[THR_W-1:1];
    assign delta = $signed({2'b00, right_raw}) - $signed({2'b00, left_raw});
    assign hs    = $signed(TD_W'(half));

    always_comb
    begin
        if (delta < hs && delta > -hs)
        begin
            adj = '0;
        end
        else if (delta < 0)
        begin
            adj = delta + hs;
        end
        else
        begin
            adj = delta - hs;
        end
    end

    assign mag_abs = adj[TD_W-1] ? -adj : adj;
    assign tden    = TRIG_FULL - TRIG_W'(half);

    always_comb
    begin
        line_next[0].pos = !adj[TD_W-1] && (adj != '0);
        line_next[0].neg = adj[TD_W-1];
        line_next[0].q   = '0;
        for (int i = 1; i < P_OUT; i++)
        begin
            line_next[i] = line_reg[i-1];
        end
        line_next[P_TDIV+DIV_STAGES].q = quo;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < P_OUT; i++)
        begin
            if (en[i])
            begin
                line_reg[i] <= line_next[i];
            end
        end
        if (en[0])
        begin
            mag_reg <= mag_abs[TRIG_W-1:0];
        end
        if (en[P_OUT])
        begin
            positive_reg <= line_reg[P_OUT-1].pos ? mag_sat : '0;
            negative_reg <= line_reg[P_OUT-1].neg ? mag_sat : '0;
        end
    end

    gdc_div u_tdiv (
        .clk (clk),
        .en  (en[P_TDIV +: DIV_STAGES]),
        .num (DIV_NUM_W'({mag_reg, {(OUT_W-1){1'b0}}})),
        .den (DIV_DEN_W'(tden)),
        .quo (quo)
    );

    assign mag_sat  = sat_q15(line_reg[P_OUT-1].q);
    assign positive = positive_reg;
    assign negative = negative_reg;

endmodule

FILE: sv/gamepad_deadzone_conditioner.sv
// top level of the gamepad deadzone conditioner
//
// sample channel: one controller sample per transfer (four signed stick axes,
// two trigger bytes, the button word). result channel: one conditioned set per
// sample, in order: eight stick half-axes and two trigger halves in unsigned
// Q1.15 (32768 is full scale) plus eight button flags.
// configuration: cfg_write with cfg_index 0 left deadzone, 1 right deadzone,
// 2 trigger threshold; other indexes are ignored. write only while idle.
// throughput: one sample per cycle while results are taken; the depth is set by the 24-step square
// root (6 stages) and the two chained 17-bit quotient dividers (5 stages each).
// every stage carries a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and samples are still taken while
// a finished result waits.
// reset clears all valid bits and loads the default deadzones and threshold.
// when the receiver stalls the result is held unchanged; the pipe fills and
// sample.ready drops only once every stage is occupied.
module gamepad_deadzone_conditioner import gdc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gdc_in_if.sink                sample,
    gdc_out_if.source             result
);

    logic [DZ_W-1:0]       left_dz_reg;
    logic [DZ_W-1:0]       right_dz_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [NUM_STAGES-1:0] en;
    logic [FLAG_W-1:0]     flag_reg [NUM_STAGES];
    logic [FLAG_W-1:0]     flags_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= LEFT_DZ_RST;
            right_dz_reg <= RIGHT_DZ_RST;
            thr_reg      <= THR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT_DZ:  left_dz_reg  <= cfg_data[DZ_W-1:0];
                REG_RIGHT_DZ: right_dz_reg <= cfg_data[DZ_W-1:0];
                REG_TRIG_THR: thr_reg      <= cfg_data[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    gdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .out_ready (result.ready),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .en        (en)
    );

    gdc_stick u_left (
        .clk        (clk),
        .en         (en),
        .deadzone   (left_dz_reg),
        .axis_x     (sample.left_stick_x),
        .axis_y     (sample.left_stick_y),
        .x_positive (result.left_x_positive),
        .x_negative (result.left_x_negative),
        .y_positive (result.left_y_positive),
        .y_negative (result.left_y_negative)
    );

    gdc_stick u_right (
        .clk        (clk),
        .en         (en),
        .deadzone   (right_dz_reg),
        .axis_x     (sample.right_stick_x),
        .axis_y     (sample.right_stick_y),
        .x_positive (result.right_x_positive),
        .x_negative (result.right_x_negative),
        .y_positive (result.right_y_positive),
        .y_negative (result.right_y_negative)
    );

    gdc_trig u_trig (
        .clk       (clk),
        .en        (en),
        .threshold (thr_reg),
        .left_raw  (sample.left_trigger_raw),
        .right_raw (sample.right_trigger_raw),
        .positive  (result.trigger_positive),
        .negative  (result.trigger_negative)
    );

    // thumbs, shoulders, dpad left/right, dpad up/down
    assign flags_in = {sample.button_word[1], sample.button_word[0],
                       sample.button_word[3], sample.button_word[2],
                       sample.button_word[9], sample.button_word[8],
                       sample.button_word[7], sample.button_word[6]};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            flag_reg[0] <= flags_in;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    assign result.button_flags = flag_reg[NUM_STAGES-1];

endmodule

FILE: sv/gdc_checker.sv
// result channel checks for the gamepad deadzone conditioner
module gdc_checker import gdc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [OUT_W-1:0]  lxp,
    input logic [OUT_W-1:0]  lxn,
    input logic [OUT_W-1:0]  lyp,
    input logic [OUT_W-1:0]  lyn,
    input logic [OUT_W-1:0]  rxp,
    input logic [OUT_W-1:0]  rxn,
    input logic [OUT_W-1:0]  ryp,
    input logic [OUT_W-1:0]  ryn,
    input logic [OUT_W-1:0]  tp,
    input logic [OUT_W-1:0]  tn,
    input logic [FLAG_W-1:0] flags
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({lxp, lxn, lyp, lyn, rxp, rxn, ryp, ryn, tp, tn, flags}))
        else $error("result changed while stalled");

    a_left_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lxp == '0 || lxn == '0) && (lyp == '0 || lyn == '0))
        else $error("left stick drives both halves of an axis");

    a_right_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rxp == '0 || rxn == '0) && (ryp == '0 || ryn == '0))
        else $error("right stick drives both halves of an axis");

    a_trig_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tp == '0 || tn == '0))
        else $error("trigger drives both halves");

    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lxp <= Q15_ONE && lxn <= Q15_ONE && lyp <= Q15_ONE
            && lyn <= Q15_ONE && rxp <= Q15_ONE && rxn <= Q15_ONE
            && ryp <= Q15_ONE && ryn <= Q15_ONE && tp <= Q15_ONE && tn <= Q15_ONE)
        else $error("output above full scale");

endmodule

bind gamepad_deadzone_conditioner gdc_checker u_gdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .lxp       (result.left_x_positive),
    .lxn       (result.left_x_negative),
    .lyp       (result.left_y_positive),
    .lyn       (result.left_y_negative),
    .rxp       (result.right_x_positive),
    .rxn       (result.right_x_negative),
    .ryp       (result.right_y_positive),
    .ryn       (result.right_y_negative),
    .tp        (result.trigger_positive),
    .tn        (result.trigger_negative),
    .flags     (result.button_flags)
);
